// ----- rtl/core/bmhq_pkg.sv -----
// Shared types, codes and sizes for the binary min-heap queue.
package bmhq_pkg;

   localparam int CAPACITY_DEF = 255;
   localparam int KEY_W        = 32;
   localparam int TOTAL_W      = 8;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 2 * KEY_W + TOTAL_W;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DEL_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic ins_start;
      logic del_start;
      logic del_load;
      logic clear;
      logic full_err;
      logic empty_err;
      logic up_read;
      logic up_move;
      logic dn_read;
      logic dn_move;
      logic place;
      logic finish_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       empty;
      logic       at_root;
      logic       has_child;
      logic       up_less;
      logic       dn_less;
   } stat_type;

endpackage

// ----- rtl/core/bmhq_ctrl.sv -----
// Sequencer for the heap queue: handshakes and sift steps.
module bmhq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  bmhq_pkg::stat_type  stat,
   output bmhq_pkg::cmd_type   cmd
);
   import bmhq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.mode)
               MODE_INSERT: state_in = stat.full ? ST_FINISH : ST_UP_RD;
               MODE_DELETE: state_in = stat.empty ? ST_FINISH : ST_DEL_LOAD;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_UP_RD:    state_in = stat.at_root ? ST_FINISH : ST_UP_CMP;
         ST_UP_CMP:   state_in = stat.up_less ? ST_UP_RD : ST_FINISH;
         ST_DEL_LOAD: state_in = ST_DN_RD;
         ST_DN_RD:    state_in = stat.has_child ? ST_DN_CMP : ST_FINISH;
         ST_DN_CMP:   state_in = stat.dn_less ? ST_DN_RD : ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.capture = req_tvalid;
         ST_DECODE: begin
            unique case (stat.mode)
               MODE_INSERT: begin
                  cmd.full_err  = stat.full;
                  cmd.ins_start = !stat.full;
               end
               MODE_DELETE: begin
                  cmd.empty_err = stat.empty;
                  cmd.del_start = !stat.empty;
               end
               MODE_CLEAR: cmd.clear = 1'b1;
               default: ;
            endcase
         end
         ST_UP_RD: begin
            cmd.place   = stat.at_root;
            cmd.up_read = !stat.at_root;
         end
         ST_UP_CMP: begin
            cmd.up_move = stat.up_less;
            cmd.place   = !stat.up_less;
         end
         ST_DEL_LOAD: cmd.del_load = 1'b1;
         ST_DN_RD: begin
            cmd.dn_read = stat.has_child;
            cmd.place   = !stat.has_child;
         end
         ST_DN_CMP: begin
            cmd.dn_move = stat.dn_less;
            cmd.place   = !stat.dn_less;
         end
         ST_FINISH: cmd.finish_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      priority if (cmd.finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/bmhq_dpath.sv -----
// Heap store, count, sift position and result registers of the heap queue.
module bmhq_dpath #(
   parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmhq_pkg::cmd_type                    cmd,
   output bmhq_pkg::stat_type                   stat,
   input  logic [1:0]                           req_mode,
   input  logic signed [bmhq_pkg::KEY_W-1:0]    req_key,
   output logic signed [bmhq_pkg::KEY_W-1:0]    rsp_removed,
   output logic [1:0]                           rsp_status,
   output logic signed [bmhq_pkg::KEY_W-1:0]    rsp_min,
   output logic [bmhq_pkg::TOTAL_W-1:0]         rsp_total
);
   import bmhq_pkg::*;

   localparam int AW = $clog2(CAPACITY + 1);

   logic signed [KEY_W-1:0] mem [0:CAPACITY];

   logic [AW-1:0]           cnt_ff, cnt_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [1:0]              mode_ff, mode_in;
   logic signed [KEY_W-1:0] hold_ff, hold_in;
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   logic [1:0]              status_ff, status_in;
   logic signed [KEY_W-1:0] root_ff;
   logic signed [KEY_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [KEY_W-1:0] out_removed_ff, out_min_ff;
   logic [1:0]              out_status_ff;
   logic [TOTAL_W-1:0]      out_total_ff;

   logic [AW:0]             child_wide;
   logic [AW-1:0]           child_l, child_r, parent, child_pos;
   logic                    has_child, right_ok, pick_r;
   logic signed [KEY_W-1:0] child_key;
   logic                    wr_en, rd_a_en;
   logic [AW-1:0]           rd_a_addr, rd_b_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic [AW+TOTAL_W-1:0]   cnt_pad;

   // children of the current position; the right one exists only when the left one lies below the count
   assign child_wide = {pos_ff, 1'b0};
   assign has_child  = child_wide <= {1'b0, cnt_ff};
   assign right_ok   = child_wide != {1'b0, cnt_ff};
   assign child_l    = child_wide[AW-1:0];
   assign child_r    = child_l + AW'(1);
   assign parent     = pos_ff >> 1;
   assign pick_r     = right_ok && (rd_b_ff < rd_a_ff);
   assign child_key  = pick_r ? rd_b_ff : rd_a_ff;
   assign child_pos  = pick_r ? child_r : child_l;
   assign cnt_pad    = {{TOTAL_W{1'b0}}, cnt_ff};

   assign stat.mode      = mode_ff;
   assign stat.full      = cnt_ff == AW'(CAPACITY);
   assign stat.empty     = cnt_ff == '0;
   assign stat.at_root   = pos_ff == AW'(1);
   assign stat.has_child = has_child;
   assign stat.up_less   = hold_ff < rd_a_ff;
   assign stat.dn_less   = child_key < hold_ff;

   // every write lands at the sift position
   assign wr_en = cmd.place || cmd.up_move || cmd.dn_move;

   always_comb begin
      priority if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_move) begin
         wr_data = child_key;
      end else begin
         wr_data = hold_ff;
      end
   end

   assign rd_a_en = cmd.del_start || cmd.up_read || cmd.dn_read;

   always_comb begin
      priority if (cmd.del_start) begin
         rd_a_addr = cnt_ff;
      end else if (cmd.up_read) begin
         rd_a_addr = parent;
      end else begin
         rd_a_addr = child_l;
      end
   end

   assign rd_b_addr = right_ok ? child_r : child_l;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (cmd.dn_read) begin
         rd_b_ff <= mem[rd_b_addr];
      end
      // shadow of the root entry for the minimum report
      if (wr_en && (pos_ff == AW'(1))) begin
         root_ff <= wr_data;
      end
   end

   always_comb begin
      priority if (cmd.clear) begin
         cnt_in = '0;
      end else if (cmd.ins_start) begin
         cnt_in = cnt_ff + AW'(1);
      end else if (cmd.del_load) begin
         cnt_in = cnt_ff - AW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_comb begin
      priority if (cmd.ins_start) begin
         pos_in = cnt_ff + AW'(1);
      end else if (cmd.del_load) begin
         pos_in = AW'(1);
      end else if (cmd.up_move) begin
         pos_in = parent;
      end else if (cmd.dn_move) begin
         pos_in = child_pos;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_comb begin
      mode_in    = cmd.capture ? req_mode : mode_ff;
      hold_in    = hold_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      priority if (cmd.capture) begin
         hold_in    = req_key;
         removed_in = '0;
         status_in  = STATUS_OK;
      end else if (cmd.del_start) begin
         removed_in = root_ff;
      end else if (cmd.del_load) begin
         hold_in    = rd_a_ff;
      end else if (cmd.full_err) begin
         status_in  = STATUS_FULL;
      end else if (cmd.empty_err) begin
         status_in  = STATUS_EMPTY;
      end else begin
         // hold the captured fields
         status_in  = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= AW'(1);
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      hold_ff    <= hold_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      if (cmd.finish_load) begin
         out_removed_ff <= removed_ff;
         out_status_ff  <= status_ff;
         out_min_ff     <= stat.empty ? '0 : root_ff;
         out_total_ff   <= cnt_pad[TOTAL_W-1:0];
      end
   end

   assign rsp_removed = out_removed_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_min     = out_min_ff;
   assign rsp_total   = out_total_ff;

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// Top level of the binary min-heap priority queue.
//
// Request channel (req_): one transfer carries an operation in req_tuser (insert,
// delete minimum, clear) and a signed key in req_tdata. Response channel (rsp_):
// every request yields exactly one transfer with the removed key, a status, the
// new minimum and the number of keys held.
// Keys live in a single-port-write, two-port-read memory of CAPACITY entries,
// heap-ordered from address 1. Equal keys never pass each other on a sift.
// Sequence: accept, decode, then for each heap level walked a registered memory
// read followed by a compare and write, then a load of the response; a delete
// first loads the last key as the one to sink from the root. Clear, errors and
// the unused mode walk no levels. One request is in flight at a time; the next
// is taken once the response is loaded.
// Reset empties the heap at once (count to zero, no clearing sweep) and drops any
// pending response. A stalled receiver holds the response register; the block
// may still take and work on the next request, and waits with that one's result
// until the held response has gone.
module binary_min_heap_queue #(
   parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] key
   input  logic [bmhq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] mode
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] removed_key, [63:32] min_key, [71:64] entry_total
   output logic [bmhq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [1:0]                           rsp_tuser
);
   import bmhq_pkg::*;

   cmd_type                 cmd;
   stat_type                stat;
   logic signed [KEY_W-1:0] rsp_removed, rsp_min;
   logic [TOTAL_W-1:0]      rsp_total;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bmhq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req_tuser),
      .req_key     (req_tdata[KEY_W-1:0]),
      .rsp_removed (rsp_removed),
      .rsp_status  (rsp_tuser),
      .rsp_min     (rsp_min),
      .rsp_total   (rsp_total)
   );

   // pack the response fields from the lowest bit up
   assign rsp_tdata = {rsp_total, rsp_min, rsp_removed};

`ifndef SYNTHESIS
   // an insert may only start below capacity
   assert property (@(posedge clock) disable iff (reset) cmd.ins_start |-> !stat.full)
      else $error("insert started on a full heap");

   // a delete may only start on a non-empty heap
   assert property (@(posedge clock) disable iff (reset) cmd.del_start |-> !stat.empty)
      else $error("delete started on an empty heap");

   // the single write port is driven by at most one command
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.place, cmd.up_move, cmd.dn_move}))
      else $error("conflicting memory writes");

   // a delete on an empty heap reports no removed key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_EMPTY)) |-> (rsp_tdata[KEY_W-1:0] == '0))
      else $error("removed key reported on empty delete");
`endif

endmodule
